@@ hdl/pcxrle_pkg.sv @@
// shared types and constants of the pcx run-length scanline decoder
package pcxrle_pkg;

    localparam int BYTE_W = 8;
    localparam int CFG_W  = 13;
    localparam int ROW_W  = 13;
    localparam int BPL_W  = 11;
    localparam int FMT_W  = 3;
    localparam int ADDR_W = 26;
    localparam int RUN_W  = 6;
    localparam int PLN_W  = 2;
    localparam int MASK_W = 4;
    localparam int IDX_W  = 2;

    localparam logic [IDX_W-1:0] CFG_IMAGE_WIDTH    = 2'd0;
    localparam logic [IDX_W-1:0] CFG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [IDX_W-1:0] CFG_BYTES_PER_LINE = 2'd2;
    localparam logic [IDX_W-1:0] CFG_PIXEL_FORMAT   = 2'd3;

    localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH    = 13'd640;
    localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT   = 13'd480;
    localparam logic [BPL_W-1:0] RST_BYTES_PER_LINE = 11'd80;
    localparam logic [FMT_W-1:0] RST_PIXEL_FORMAT   = 3'd4;

    localparam logic [FMT_W-1:0] FMT_PLANAR_LAST = 3'd3;
    localparam logic [FMT_W-1:0] FMT_24BIT       = 3'd5;

    localparam logic [BYTE_W-1:0] RUN_HEADER   = 8'd192;
    localparam logic [PLN_W-1:0]  PLANES_24BIT = 2'd2;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    typedef struct packed {
        logic emit;
        logic last;
        logic use_held;
        logic take_hdr;
        logic start_run;
    } t_cmd;

    typedef struct packed {
        logic can_emit;
        logic ignore;
        logic awaiting;
        logic is_hdr;
        logic run_zero;
        logic run_one;
        logic rem_one;
        logic row_end;
    } t_status;

endpackage

@@ hdl/pcxrle_in_if.sv @@
// input word channel: compressed stream bytes
interface pcxrle_in_if;
    logic                          valid;
    logic                          ready;
    logic [pcxrle_pkg::BYTE_W-1:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink (input valid, input stream_byte, output ready);
endinterface

@@ hdl/pcxrle_out_if.sv @@
// output word channel: frame-buffer writes
interface pcxrle_out_if;
    logic                          valid;
    logic                          ready;
    logic [pcxrle_pkg::ADDR_W-1:0] write_address;
    logic [pcxrle_pkg::BYTE_W-1:0] data_byte;
    logic                          write_kind;
    logic [pcxrle_pkg::MASK_W-1:0] plane_mask;
    logic                          last_of_item;
    logic                          image_done;

    modport source (
        output valid, output write_address, output data_byte, output write_kind,
        output plane_mask, output last_of_item, output image_done, input ready
    );
    modport sink (
        input valid, input write_address, input data_byte, input write_kind,
        input plane_mask, input last_of_item, input image_done, output ready
    );
endinterface

@@ hdl/pcx_rle_scanline_decoder_top.sv @@
// a write is loaded into the output register by the clock edge that takes its input word
// throughput: a literal word gives one write; a run of n repeats gives up to n writes, the data word
//   is taken with the first repeat and the input is held for the others, one repeat per cycle
//   while the output register has room, set by its single write port; a row end cuts the run short
// run headers and ignored words are taken without producing a write
// reset: synchronous active low, clears the run state, position counters and output valid,
//   and loads the default picture geometry (640 x 480, 80 bytes per line, 8-bit pixels)
module pcx_rle_scanline_decoder_top #(
    parameter int MAX_WIDTH      = 4096,
    parameter int MAX_HEIGHT     = 4096,
    parameter int MAX_LINE_BYTES = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    pcxrle_in_if.sink                    i_in,
    pcxrle_out_if.source                 o_out,
    input  logic                         i_cfg_we,
    input  logic [pcxrle_pkg::IDX_W-1:0] i_cfg_index,
    input  logic [pcxrle_pkg::CFG_W-1:0] i_cfg_data
);

    pcxrle_pkg::t_cmd    cmd;
    pcxrle_pkg::t_status st;

    pcxrle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    pcxrle_dp #(
        .MAX_WIDTH      (MAX_WIDTH),
        .MAX_HEIGHT     (MAX_HEIGHT),
        .MAX_LINE_BYTES (MAX_LINE_BYTES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_stream_byte   (i_in.stream_byte),
        .i_out_ready     (o_out.ready),
        .i_cmd           (cmd),
        .o_st            (st),
        .o_out_valid     (o_out.valid),
        .o_write_address (o_out.write_address),
        .o_data_byte     (o_out.data_byte),
        .o_write_kind    (o_out.write_kind),
        .o_plane_mask    (o_out.plane_mask),
        .o_last_of_item  (o_out.last_of_item),
        .o_image_done    (o_out.image_done)
    );

endmodule

@@ hdl/pcxrle_ctrl.sv @@
// control state machine: literal, run header and run repeat sequencing
module pcxrle_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  pcxrle_pkg::t_status i_st,
    output pcxrle_pkg::t_cmd    o_cmd
);

    pcxrle_pkg::t_state r_state;
    pcxrle_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcxrle_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            pcxrle_pkg::S_IDLE: begin
                o_in_ready = i_st.can_emit;
                if (i_in_valid && i_st.can_emit && !i_st.ignore) begin
                    if (!i_st.awaiting) begin
                        if (i_st.is_hdr) begin
                            o_cmd.take_hdr = 1'b1;
                        end else begin
                            o_cmd.emit = 1'b1;
                            o_cmd.last = 1'b1;
                        end
                    end else begin
                        o_cmd.start_run = 1'b1;
                        if (!i_st.run_zero) begin
                            o_cmd.emit = 1'b1;
                            o_cmd.last = i_st.row_end || i_st.run_one;
                            if (!o_cmd.last) begin
                                n_state = pcxrle_pkg::S_RUN;
                            end
                        end
                    end
                end
            end
            pcxrle_pkg::S_RUN: begin
                if (i_st.can_emit) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.use_held = 1'b1;
                    o_cmd.last     = i_st.row_end || i_st.rem_one;
                    if (o_cmd.last) begin
                        n_state = pcxrle_pkg::S_IDLE;
                    end
                end
            end
            default: n_state = pcxrle_pkg::S_IDLE;
        endcase
    end

    a_run_not_awaiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == pcxrle_pkg::S_RUN |-> !i_st.awaiting)
        else $error("run repeat while awaiting run data");

    a_hdr_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.take_hdr |-> !o_cmd.emit && !o_cmd.start_run)
        else $error("run header produced a write");

    a_run_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == pcxrle_pkg::S_RUN && o_cmd.emit && o_cmd.last
        |=> r_state == pcxrle_pkg::S_IDLE)
        else $error("run did not end after its last write");

endmodule

@@ hdl/pcxrle_dp.sv @@
// datapath: config registers, position counters, address generation, output register
module pcxrle_dp #(
    parameter int MAX_WIDTH      = 4096,
    parameter int MAX_HEIGHT     = 4096,
    parameter int MAX_LINE_BYTES = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pcxrle_pkg::IDX_W-1:0]        i_cfg_index,
    input  logic [pcxrle_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic [pcxrle_pkg::BYTE_W-1:0]       i_stream_byte,
    input  logic                                i_out_ready,
    input  pcxrle_pkg::t_cmd                    i_cmd,
    output pcxrle_pkg::t_status                 o_st,
    output logic                                o_out_valid,
    output logic [pcxrle_pkg::ADDR_W-1:0]       o_write_address,
    output logic [pcxrle_pkg::BYTE_W-1:0]       o_data_byte,
    output logic                                o_write_kind,
    output logic [pcxrle_pkg::MASK_W-1:0]       o_plane_mask,
    output logic                                o_last_of_item,
    output logic                                o_image_done
);

    localparam int LINE_PIX = MAX_LINE_BYTES * 8;
    localparam int LINE_MAX = (MAX_WIDTH > LINE_PIX) ? MAX_WIDTH : LINE_PIX;
    localparam int COL_W    = $clog2(LINE_MAX + 8);
    localparam int AW       = pcxrle_pkg::ADDR_W;

    logic [pcxrle_pkg::CFG_W-1:0]  r_width;
    logic [pcxrle_pkg::CFG_W-1:0]  r_height;
    logic [pcxrle_pkg::BPL_W-1:0]  r_bpl;
    logic [pcxrle_pkg::FMT_W-1:0]  r_fmt;

    logic                          r_awaiting;
    logic [pcxrle_pkg::RUN_W-1:0]  r_run_len;
    logic [pcxrle_pkg::RUN_W-1:0]  r_rem;
    logic [pcxrle_pkg::BYTE_W-1:0] r_hold;
    logic [COL_W-1:0]              r_col;
    logic [pcxrle_pkg::ROW_W-1:0]  r_row;
    logic [pcxrle_pkg::PLN_W-1:0]  r_plane;
    logic [AW-1:0]                 r_row_base;
    logic [AW-1:0]                 r_pix;
    logic                          r_finished;

    logic                          r_out_valid;
    logic [AW-1:0]                 r_o_addr;
    logic [pcxrle_pkg::BYTE_W-1:0] r_o_data;
    logic                          r_o_kind;
    logic [pcxrle_pkg::MASK_W-1:0] r_o_mask;
    logic                          r_o_last;
    logic                          r_o_done;

    logic [31:0]                   width_sat;
    logic [31:0]                   height_sat;
    logic [31:0]                   bpl_sat;
    logic [COL_W-1:0]              width_used;
    logic                          planar;
    logic                          fmt24;
    logic [COL_W-1:0]              line_len;
    logic [COL_W-1:0]              inc;
    logic [2:0]                    planes;
    logic [COL_W-1:0]              col_next;
    logic                          line_end;
    logic                          last_plane;
    logic                          row_end;
    logic [pcxrle_pkg::ROW_W-1:0]  row_next;
    logic                          done;
    logic [pcxrle_pkg::PLN_W-1:0]  byte_off;
    logic [AW-1:0]                 addr24;
    logic [AW-1:0]                 next_base;

    always_comb begin
        width_sat  = (32'(r_width) > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : 32'(r_width);
        height_sat = (32'(r_height) > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : 32'(r_height);
        bpl_sat    = (32'(r_bpl) > 32'(MAX_LINE_BYTES)) ? 32'(MAX_LINE_BYTES) : 32'(r_bpl);
        width_used = COL_W'(width_sat);
        planar     = (r_fmt <= pcxrle_pkg::FMT_PLANAR_LAST);
        fmt24      = (r_fmt == pcxrle_pkg::FMT_24BIT);
        if (planar) begin
            line_len = COL_W'(bpl_sat << 3);
            inc      = COL_W'(8);
            planes   = {1'b0, r_fmt[1:0]} + 3'd1;
        end else if (fmt24) begin
            line_len = width_used;
            inc      = COL_W'(1);
            planes   = 3'd3;
        end else begin
            line_len = width_used;
            inc      = COL_W'(1);
            planes   = 3'd1;
        end
        col_next   = r_col + inc;
        line_end   = (col_next >= line_len);
        last_plane = (({1'b0, r_plane} + 3'd1) >= planes);
        row_end    = line_end && last_plane;
        row_next   = r_row + pcxrle_pkg::ROW_W'(1);
        done       = row_end && (32'(row_next) >= height_sat);
        byte_off   = pcxrle_pkg::PLANES_24BIT - r_plane;
        addr24     = r_pix + {r_pix[AW-2:0], 1'b0} + AW'(byte_off);
        next_base  = r_row_base + AW'(width_used);
    end

    always_comb begin
        o_st          = '0;
        o_st.can_emit = !r_out_valid || i_out_ready;
        o_st.ignore   = r_finished || (32'(r_row) >= height_sat);
        o_st.awaiting = r_awaiting;
        o_st.is_hdr   = (i_stream_byte >= pcxrle_pkg::RUN_HEADER);
        o_st.run_zero = (r_run_len == '0);
        o_st.run_one  = (r_run_len == pcxrle_pkg::RUN_W'(1));
        o_st.rem_one  = (r_rem == pcxrle_pkg::RUN_W'(1));
        o_st.row_end  = row_end;
    end

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= pcxrle_pkg::RST_IMAGE_WIDTH;
            r_height <= pcxrle_pkg::RST_IMAGE_HEIGHT;
            r_bpl    <= pcxrle_pkg::RST_BYTES_PER_LINE;
            r_fmt    <= pcxrle_pkg::RST_PIXEL_FORMAT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pcxrle_pkg::CFG_IMAGE_WIDTH:    r_width  <= i_cfg_data;
                pcxrle_pkg::CFG_IMAGE_HEIGHT:   r_height <= i_cfg_data;
                pcxrle_pkg::CFG_BYTES_PER_LINE: r_bpl    <= i_cfg_data[pcxrle_pkg::BPL_W-1:0];
                pcxrle_pkg::CFG_PIXEL_FORMAT:   r_fmt    <= i_cfg_data[pcxrle_pkg::FMT_W-1:0];
                default: ;
            endcase
        end
    end

    // run state and position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_awaiting <= 1'b0;
            r_run_len  <= '0;
            r_rem      <= '0;
            r_col      <= '0;
            r_row      <= '0;
            r_plane    <= '0;
            r_row_base <= '0;
            r_pix      <= '0;
            r_finished <= 1'b0;
        end else begin
            if (i_cmd.take_hdr) begin
                r_awaiting <= 1'b1;
                r_run_len  <= i_stream_byte[pcxrle_pkg::RUN_W-1:0];
            end
            if (i_cmd.start_run) begin
                r_awaiting <= 1'b0;
                r_rem      <= r_run_len - pcxrle_pkg::RUN_W'(1);
            end else if (i_cmd.emit && i_cmd.use_held) begin
                r_rem <= r_rem - pcxrle_pkg::RUN_W'(1);
            end
            if (i_cmd.emit) begin
                if (line_end) begin
                    r_col <= '0;
                    if (last_plane) begin
                        r_plane    <= '0;
                        r_row      <= row_next;
                        r_row_base <= next_base;
                        r_pix      <= next_base;
                        if (done) begin
                            r_finished <= 1'b1;
                        end
                    end else begin
                        r_plane <= r_plane + pcxrle_pkg::PLN_W'(1);
                        r_pix   <= r_row_base;
                    end
                end else begin
                    r_col <= col_next;
                    r_pix <= r_pix + AW'(inc);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_run) begin
            r_hold <= i_stream_byte;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_addr <= fmt24 ? addr24 : r_pix;
            r_o_data <= i_cmd.use_held ? r_hold : i_stream_byte;
            r_o_kind <= planar;
            r_o_mask <= pcxrle_pkg::MASK_W'(1) << r_plane;
            r_o_last <= i_cmd.last;
            r_o_done <= done;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_write_address = r_o_addr;
    assign o_data_byte     = r_o_data;
    assign o_write_kind    = r_o_kind;
    assign o_plane_mask    = r_o_mask;
    assign o_last_of_item  = r_o_last;
    assign o_image_done    = r_o_done;

    a_done_sets_finished: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit && done |=> r_finished)
        else $error("final row write did not finish the image");

    a_emit_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> !r_out_valid || i_out_ready)
        else $error("write overran the output register");

    a_position_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.emit |=> $stable(r_col) && $stable(r_row) && $stable(r_plane))
        else $error("position moved without a write");

endmodule

@@ verif/tb.sv @@
// self-checking testbench for the pcx run-length scanline decoder
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_W        = 4096;
    localparam int MAX_H        = 4096;
    localparam int MAX_LB       = 1024;
    localparam int IDLE_PCT     = 20;
    localparam int SETTLE       = 4;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASES       = 8;
    localparam int PHASE_WORDS  = 22;

    typedef enum logic [pcxrle_pkg::FMT_W-1:0] {
        PF_1BIT, PF_2BIT, PF_3BIT, PF_4BIT, PF_8BIT, PF_24BIT, PF_ALIAS6, PF_ALIAS7
    } t_pix_fmt;

    typedef enum logic {
        ROW_WORD,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        logic [pcxrle_pkg::ADDR_W-1:0] addr;
        logic [pcxrle_pkg::BYTE_W-1:0] data;
        logic                          kind;
        logic [pcxrle_pkg::MASK_W-1:0] mask;
        logic                          last;
        logic                          done;
    } t_fb_write;

    typedef struct packed {
        t_row_kind                    kind;
        logic [pcxrle_pkg::IDX_W-1:0] idx;
        logic [pcxrle_pkg::CFG_W-1:0] val;
        bit                           typed;
        t_fb_write                    exp;
    } t_stim_row;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         cfg_we;
    logic [pcxrle_pkg::IDX_W-1:0] cfg_index;
    logic [pcxrle_pkg::CFG_W-1:0] cfg_data;
    bit                           calm = 1'b0;

    pcxrle_in_if  in_word_if();
    pcxrle_out_if fb_write_if();

    pcx_rle_scanline_decoder_top #(
        .MAX_WIDTH     (MAX_W),
        .MAX_HEIGHT    (MAX_H),
        .MAX_LINE_BYTES(MAX_LB)
    ) u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_word_if),
        .o_out      (fb_write_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // decoder shadow: geometry and scan position
    logic [pcxrle_pkg::CFG_W-1:0]  cfg_width  = pcxrle_pkg::RST_IMAGE_WIDTH;
    logic [pcxrle_pkg::CFG_W-1:0]  cfg_height = pcxrle_pkg::RST_IMAGE_HEIGHT;
    logic [pcxrle_pkg::BPL_W-1:0]  cfg_bpl    = pcxrle_pkg::RST_BYTES_PER_LINE;
    logic [pcxrle_pkg::FMT_W-1:0]  cfg_format = pcxrle_pkg::RST_PIXEL_FORMAT;
    bit                            dec_awaiting = 1'b0;
    logic [pcxrle_pkg::RUN_W-1:0]  dec_run      = '0;
    int unsigned                   dec_col      = 0;
    logic [pcxrle_pkg::ROW_W-1:0]  dec_row      = '0;
    logic [pcxrle_pkg::PLN_W-1:0]  dec_plane    = '0;
    logic [pcxrle_pkg::ADDR_W-1:0] dec_row_base = '0;
    bit                            dec_finished = 1'b0;

    t_fb_write pending_writes[$];
    int        words_sent  = 0;
    int        writes_seen = 0;
    int        mismatches  = 0;
    int        cycles      = 0;

    function automatic int unsigned used_height();
        return (cfg_height > MAX_H) ? MAX_H : cfg_height;
    endfunction

    // one frame-buffer write at the current position; returns high at a row end
    function automatic bit place_byte(input logic [pcxrle_pkg::BYTE_W-1:0] b,
                                      output t_fb_write w);
        int unsigned     width;
        int unsigned     planes;
        int unsigned     line_len;
        longint unsigned addr;
        bit              row_end;
        width   = (cfg_width > MAX_W) ? MAX_W : cfg_width;
        row_end = 1'b0;
        w       = '0;
        if (cfg_format <= pcxrle_pkg::FMT_PLANAR_LAST) begin
            planes   = cfg_format + 1;
            line_len = ((cfg_bpl > MAX_LB) ? MAX_LB : cfg_bpl) * 8;
            addr     = dec_row_base + dec_col;
            w.kind   = 1'b1;
            dec_col += 8;
        end else if (cfg_format == pcxrle_pkg::FMT_24BIT) begin
            planes   = 3;
            line_len = width;
            addr     = (dec_row_base + dec_col) * 3 + ((2 - int'(dec_plane)) & 3);
            dec_col += 1;
        end else begin
            planes   = 1;
            line_len = width;
            addr     = dec_row_base + dec_col;
            dec_col += 1;
        end
        w.addr = pcxrle_pkg::ADDR_W'(addr);
        w.data = b;
        w.mask = pcxrle_pkg::MASK_W'(1 << dec_plane);
        if (dec_col >= line_len) begin
            dec_col = 0;
            if (int'(dec_plane) + 1 >= planes) begin
                dec_plane    = '0;
                dec_row      = dec_row + 1'b1;
                dec_row_base = dec_row_base + pcxrle_pkg::ADDR_W'(width);
                row_end      = 1'b1;
                if (dec_row >= used_height()) begin
                    dec_finished = 1'b1;
                    w.done       = 1'b1;
                end
            end else begin
                dec_plane = dec_plane + 1'b1;
            end
        end
        return row_end;
    endfunction

    function automatic void decode_word(input logic [pcxrle_pkg::BYTE_W-1:0] b);
        int unsigned count;
        int unsigned n;
        bit          row_end;
        t_fb_write   w;
        if (dec_finished || dec_row >= used_height()) return;
        if (!dec_awaiting) begin
            if (b >= pcxrle_pkg::RUN_HEADER) begin
                dec_awaiting = 1'b1;
                dec_run      = b[pcxrle_pkg::RUN_W-1:0];
                return;
            end
            count = 1;
        end else begin
            dec_awaiting = 1'b0;
            count        = dec_run;
        end
        n       = 0;
        row_end = 1'b0;
        while (n < count && !row_end) begin
            row_end = place_byte(b, w);
            n++;
            w.last = (n == count) || row_end;
            pending_writes.push_back(w);
        end
    endfunction

    task automatic drain_writes();
        in_word_if.valid <= 1'b0;
        while (pending_writes.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_reg(input logic [pcxrle_pkg::IDX_W-1:0] idx,
                           input logic [pcxrle_pkg::CFG_W-1:0] val);
        drain_writes();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            pcxrle_pkg::CFG_IMAGE_WIDTH:    cfg_width  = val;
            pcxrle_pkg::CFG_IMAGE_HEIGHT:   cfg_height = val;
            pcxrle_pkg::CFG_BYTES_PER_LINE: cfg_bpl    = val[pcxrle_pkg::BPL_W-1:0];
            pcxrle_pkg::CFG_PIXEL_FORMAT:   cfg_format = val[pcxrle_pkg::FMT_W-1:0];
            default: ;
        endcase
    endtask

    // the word is predicted as soon as it is offered, since it is never withdrawn
    task automatic send_word(input logic [pcxrle_pkg::BYTE_W-1:0] b, input bit typed = 1'b0,
                             input t_fb_write typed_write = '0);
        bit took;
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            in_word_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_word_if.valid       <= 1'b1;
        in_word_if.stream_byte <= b;
        decode_word(b);
        if (typed) begin
            void'(pending_writes.pop_back());
            pending_writes.push_back(typed_write);
        end
        words_sent++;
        // ready is sampled ahead of the edge that would take the word
        took = 1'b0;
        while (!took) begin
            @(negedge clk);
            took = in_word_if.ready;
            @(posedge clk);
        end
    endtask

    task automatic report_field(input string field, input longint unsigned want,
                                input longint unsigned seen);
        mismatches++;
        $display("%0t mismatch on %s: expected %0h, actual %0h", $time, field, want, seen);
    endtask

    always @(posedge clk) begin
        fb_write_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    t_fb_write seen_write;
    t_fb_write want_write;

    always @(posedge clk) begin
        if (rst_n && fb_write_if.valid && fb_write_if.ready) begin
            seen_write = '{fb_write_if.write_address, fb_write_if.data_byte,
                           fb_write_if.write_kind, fb_write_if.plane_mask,
                           fb_write_if.last_of_item, fb_write_if.image_done};
            writes_seen++;
            if (pending_writes.size() == 0) begin
                mismatches++;
                $display("%0t unexpected write: expected none, actual addr %0h data %0h",
                         $time, seen_write.addr, seen_write.data);
            end else begin
                want_write = pending_writes.pop_front();
                if (seen_write.addr !== want_write.addr)
                    report_field("write_address", want_write.addr, seen_write.addr);
                if (seen_write.data !== want_write.data)
                    report_field("data_byte", want_write.data, seen_write.data);
                if (seen_write.kind !== want_write.kind)
                    report_field("write_kind", want_write.kind, seen_write.kind);
                if (seen_write.mask !== want_write.mask)
                    report_field("plane_mask", want_write.mask, seen_write.mask);
                if (seen_write.last !== want_write.last)
                    report_field("last_of_item", want_write.last, seen_write.last);
                if (seen_write.done !== want_write.done)
                    report_field("image_done", want_write.done, seen_write.done);
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d writes still expected",
                     cycles, pending_writes.size());
            $display("Some tests failed");
            $finish;
        end
    end

    t_stim_row dir_tab [41] = '{
        '{ROW_WORD, '0, 13'h000, 1'b1, '{26'd0, 8'h00, 1'b0, 4'd1, 1'b1, 1'b0}},
        '{ROW_WORD, '0, 13'h0BF, 1'b1, '{26'd1, 8'hBF, 1'b0, 4'd1, 1'b1, 1'b0}},
        '{ROW_WORD, '0, 13'h0C0, 1'b0, '0},
        '{ROW_WORD, '0, 13'h0FF, 1'b0, '0},
        '{ROW_WORD, '0, 13'h0FF, 1'b0, '0},
        '{ROW_WORD, '0, 13'h0C0, 1'b0, '0},
        '{ROW_CFG, pcxrle_pkg::CFG_IMAGE_WIDTH, 13'd4, 1'b0, '0},
        '{ROW_WORD, '0, 13'h0C5, 1'b0, '0},
        '{ROW_WORD, '0, 13'h07E, 1'b0, '0},
        '{ROW_WORD, '0, 13'h0C5, 1'b0, '0},
        '{ROW_WORD, '0, 13'h011, 1'b0, '0},
        '{ROW_CFG, pcxrle_pkg::CFG_PIXEL_FORMAT, 13'(PF_24BIT), 1'b0, '0},
        '{ROW_CFG, pcxrle_pkg::CFG_IMAGE_WIDTH, 13'd2, 1'b0, '0},
        '{ROW_WORD, '0, 13'h080, 1'b0, '0},
        '{ROW_WORD, '0, 13'h0C6, 1'b0, '0},
        '{ROW_WORD, '0, 13'h03C, 1'b0, '0},
        '{ROW_CFG, pcxrle_pkg::CFG_PIXEL_FORMAT, 13'(PF_1BIT), 1'b0, '0},
        '{ROW_CFG, pcxrle_pkg::CFG_BYTES_PER_LINE, 13'd1, 1'b0, '0},
        '{ROW_WORD, '0, 13'h081, 1'b0, '0},
        '{ROW_CFG, pcxrle_pkg::CFG_PIXEL_FORMAT, 13'(PF_4BIT), 1'b0, '0},
        '{ROW_CFG, pcxrle_pkg::CFG_BYTES_PER_LINE, 13'd2, 1'b0, '0},
        '{ROW_WORD, '0, 13'h0C8, 1'b0, '0},
        '{ROW_WORD, '0, 13'h0A5, 1'b0, '0},
        '{ROW_CFG, pcxrle_pkg::CFG_PIXEL_FORMAT, 13'(PF_ALIAS7), 1'b0, '0},
        '{ROW_CFG, pcxrle_pkg::CFG_IMAGE_WIDTH, 13'd3, 1'b0, '0},
        '{ROW_WORD, '0, 13'h042, 1'b0, '0},
        '{ROW_WORD, '0, 13'h043, 1'b0, '0},
        '{ROW_CFG, pcxrle_pkg::CFG_PIXEL_FORMAT, 13'(PF_ALIAS6), 1'b0, '0},
        '{ROW_WORD, '0, 13'h0C2, 1'b0, '0},
        '{ROW_WORD, '0, 13'h044, 1'b0, '0},
        '{ROW_CFG, pcxrle_pkg::CFG_PIXEL_FORMAT, 13'(PF_4BIT), 1'b0, '0},
        '{ROW_CFG, pcxrle_pkg::CFG_BYTES_PER_LINE, 13'd1, 1'b0, '0},
        '{ROW_WORD, '0, 13'h001, 1'b0, '0},
        '{ROW_WORD, '0, 13'h002, 1'b0, '0},
        '{ROW_WORD, '0, 13'h004, 1'b0, '0},
        // plane three carried into 24-bit mode
        '{ROW_CFG, pcxrle_pkg::CFG_PIXEL_FORMAT, 13'(PF_24BIT), 1'b0, '0},
        '{ROW_CFG, pcxrle_pkg::CFG_IMAGE_WIDTH, 13'd1, 1'b0, '0},
        '{ROW_WORD, '0, 13'h008, 1'b0, '0},
        '{ROW_CFG, pcxrle_pkg::CFG_IMAGE_HEIGHT, 13'd1, 1'b0, '0},
        '{ROW_WORD, '0, 13'h010, 1'b0, '0},
        '{ROW_CFG, pcxrle_pkg::CFG_IMAGE_HEIGHT, 13'h1FFF, 1'b0, '0}
    };

    initial begin
        int                           roll;
        logic [pcxrle_pkg::CFG_W-1:0] wid;
        logic [pcxrle_pkg::CFG_W-1:0] hgt;
        logic [pcxrle_pkg::CFG_W-1:0] bpl;
        logic [pcxrle_pkg::CFG_W-1:0] fmt;
        in_word_if.valid       = 1'b0;
        in_word_if.stream_byte = '0;
        fb_write_if.ready      = 1'b0;
        cfg_we                 = 1'b0;
        cfg_index              = '0;
        cfg_data               = '0;
        rst_n                  = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_CFG)
                set_reg(dir_tab[i].idx, dir_tab[i].val);
            else
                send_word(dir_tab[i].val[pcxrle_pkg::BYTE_W-1:0], dir_tab[i].typed,
                          dir_tab[i].exp);
        end

        for (int p = 0; p < PHASES; p++) begin
            calm = (p == 3 || p == 4);
            roll = $urandom_range(9);
            wid  = (roll == 0) ? 13'd1 : (roll == 1) ? 13'd4096 : (roll == 2) ? 13'h1FFF
                 : pcxrle_pkg::CFG_W'($urandom_range(40, 2));
            roll = $urandom_range(9);
            bpl  = (roll == 0) ? 13'd1 : (roll == 1) ? 13'd1024 : (roll == 2) ? 13'd2047
                 : pcxrle_pkg::CFG_W'($urandom_range(6, 1));
            roll = $urandom_range(9);
            hgt  = (roll < 2) ? 13'h1FFF : (roll < 4) ? 13'd4096
                 : pcxrle_pkg::CFG_W'(int'(dec_row) + $urandom_range(3000, 300));
            fmt  = pcxrle_pkg::CFG_W'($urandom_range(7));
            set_reg(pcxrle_pkg::CFG_IMAGE_WIDTH, wid);
            set_reg(pcxrle_pkg::CFG_IMAGE_HEIGHT, hgt);
            set_reg(pcxrle_pkg::CFG_BYTES_PER_LINE, bpl);
            set_reg(pcxrle_pkg::CFG_PIXEL_FORMAT, fmt);
            for (int i = 0; i < PHASE_WORDS; i++) begin
                roll = $urandom_range(99);
                if (roll < 55) begin
                    send_word(pcxrle_pkg::BYTE_W'($urandom_range(191)));
                end else if (roll < 88) begin
                    send_word(pcxrle_pkg::BYTE_W'($urandom_range(255, 192)));
                    send_word(pcxrle_pkg::BYTE_W'($urandom));
                    i++;
                end else begin
                    send_word(pcxrle_pkg::BYTE_W'($urandom));
                end
            end
        end
        calm = 1'b0;

        // close the picture two rows on, then show that later words are dropped
        set_reg(pcxrle_pkg::CFG_IMAGE_HEIGHT, pcxrle_pkg::CFG_W'(dec_row + 2'd2));
        set_reg(pcxrle_pkg::CFG_PIXEL_FORMAT, pcxrle_pkg::CFG_W'(PF_8BIT));
        set_reg(pcxrle_pkg::CFG_IMAGE_WIDTH, 13'd3);
        repeat (12) send_word(pcxrle_pkg::BYTE_W'($urandom_range(191)));
        send_word(8'hC5);
        send_word(8'h99);
        drain_writes();

        $display("%0d stream words sent, %0d frame writes checked, %0d rows decoded",
                 words_sent, writes_seen, dec_row);
        $display("covered all pixel formats, saturated and minimal geometry, runs and a closed picture");
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/pcxrle_pkg.sv
hdl/pcxrle_in_if.sv
hdl/pcxrle_out_if.sv
hdl/pcxrle_ctrl.sv
hdl/pcxrle_dp.sv
hdl/pcx_rle_scanline_decoder_top.sv
verif/tb.sv
